### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define AFFT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("afft: property failed");

// Signal that must never be true out of reset.
`define AFFT_NEVER(lbl, clk, rst_n, expr) \
	`AFFT_ASSERT(lbl, clk, rst_n, !(expr))

`endif

### rtl/afft_pkg.sv
// Shared types and constants of the affine point transform.
`timescale 1ns / 1ps
package afft_pkg;
	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int NUM_REGS       = 6;
	localparam int NUM_ROWS       = 3;
	localparam int REG_IDX_BITS   = 3;
	localparam int PADDR_BITS     = 6;

	// Register indexes (byte address = 8 * index)
	localparam logic [REG_IDX_BITS-1:0] REG_ROW0_C01 = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW0_C23 = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW1_C01 = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW1_C23 = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW2_C01 = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_ROW2_C23 = 3'd5;

	// One matrix row, raw 32-bit elements; m3 is the translation
	typedef struct packed {
		logic [31:0] m3;
		logic [31:0] m2;
		logic [31:0] m1;
		logic [31:0] m0;
	} row_coef_t;
endpackage

### rtl/afft_regs.sv
// Matrix register file behind the APB-style configuration port.
`timescale 1ns / 1ps
module afft_regs
	import afft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready,
	output row_coef_t             rows [NUM_ROWS]
);
	logic [63:0]             mat_q [NUM_REGS];
	logic [REG_IDX_BITS-1:0] idx;
	logic                    wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_BITS-1:3];
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				mat_q[i] <= '0;
			end
		end else if (wr_en && (idx <= REG_ROW2_C23)) begin
			mat_q[idx] <= pwdata;
		end
	end

	always_comb begin
		case (idx)
			REG_ROW0_C01: prdata = mat_q[0];
			REG_ROW0_C23: prdata = mat_q[1];
			REG_ROW1_C01: prdata = mat_q[2];
			REG_ROW1_C23: prdata = mat_q[3];
			REG_ROW2_C01: prdata = mat_q[4];
			REG_ROW2_C23: prdata = mat_q[5];
			default:      prdata = '0;
		endcase
	end

	// low half is the first element of the pair, high half the second
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			rows[r].m0 = mat_q[2*r][31:0];
			rows[r].m1 = mat_q[2*r][63:32];
			rows[r].m2 = mat_q[2*r+1][31:0];
			rows[r].m3 = mat_q[2*r+1][63:32];
		end
	end
endmodule

### rtl/afft_row.sv
// One matrix row: multiply, sum, floor shift, translate and saturate.
`timescale 1ns / 1ps
module afft_row
	import afft_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  row_coef_t                    coef,
	input  logic signed [COORD_BITS-1:0] x_s1,
	input  logic signed [COORD_BITS-1:0] y_s1,
	input  logic signed [COORD_BITS-1:0] z_s1,
	output logic signed [31:0]           res_s4
);
	localparam int PW = 2 * COORD_BITS;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	logic signed [COORD_BITS-1:0] c0, c1, c2, c3;
	logic signed [PW-1:0]         p0_s2, p1_s2, p2_s2;
	logic signed [SW-1:0]         sum_s3;
	logic signed [SW-1:0]         shifted, total;
	logic signed [COORD_BITS-1:0] sat;

	assign c0 = $signed(coef.m0[COORD_BITS-1:0]);
	assign c1 = $signed(coef.m1[COORD_BITS-1:0]);
	assign c2 = $signed(coef.m2[COORD_BITS-1:0]);
	assign c3 = $signed(coef.m3[COORD_BITS-1:0]);

	always_ff @(posedge clk) begin
		p0_s2 <= c0 * x_s1;
		p1_s2 <= c1 * y_s1;
		p2_s2 <= c2 * z_s1;
	end

	// exact sum of the three full products
	always_ff @(posedge clk) begin
		sum_s3 <= SW'(p0_s2) + SW'(p1_s2) + SW'(p2_s2);
	end

	// arithmetic shift floors toward negative infinity
	assign shifted = sum_s3 >>> FRAC_BITS;
	assign total   = shifted + SW'(c3);

	always_comb begin
		if (total > SAT_HI) begin
			sat = SAT_HI[COORD_BITS-1:0];
		end else if (total < SAT_LO) begin
			sat = SAT_LO[COORD_BITS-1:0];
		end else begin
			sat = total[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		res_s4 <= 32'(sat);
	end
endmodule

### rtl/affine_point_transform_unit.sv
// Top level of the affine 3x4 matrix point transform.
`timescale 1ns / 1ps
//
// Channel   Handshake                    Payload
// input     start (busy tied low)        in_x, in_y, in_z, last_in
// result    done, one cycle per word     out_x, out_y, out_z, last_out
// config    APB psel/penable/pwrite      paddr, pwdata, prdata (64-bit regs)
//
// One word enters per cycle; the result leaves on done for one cycle.
// The stage chain: input capture, 32x32 multipliers, three-way product
// sum, shift / translate / saturate.
// Reset clears the valid bits and the matrix registers to zero.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
module affine_point_transform_unit
	import afft_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input words
	input  logic                  start,
	output logic                  busy,
	input  logic signed [31:0]    in_x,
	input  logic signed [31:0]    in_y,
	input  logic signed [31:0]    in_z,
	input  logic                  last_in,
	// result words
	output logic                  done,
	output logic signed [31:0]    out_x,
	output logic signed [31:0]    out_y,
	output logic signed [31:0]    out_z,
	output logic                  last_out,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready
);
	row_coef_t                    rows [NUM_ROWS];
	logic                         accept;
	logic                         v_s1, v_s2, v_s3, v_s4;
	logic                         last_s1, last_s2, last_s3, last_s4;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;

	// No back pressure anywhere: accept every start.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	afft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rows    (rows)
	);

	// Advance the valid bits with the data, one stage per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Capture the point; drop bits above the coordinate width.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= in_x[COORD_BITS-1:0];
			y_s1 <= in_y[COORD_BITS-1:0];
			z_s1 <= in_z[COORD_BITS-1:0];
		end
		last_s1 <= last_in;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
	end

	afft_row #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_row_x (
		.clk (clk), .coef (rows[0]), .x_s1 (x_s1), .y_s1 (y_s1), .z_s1 (z_s1),
		.res_s4 (out_x)
	);

	afft_row #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_row_y (
		.clk (clk), .coef (rows[1]), .x_s1 (x_s1), .y_s1 (y_s1), .z_s1 (z_s1),
		.res_s4 (out_y)
	);

	afft_row #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_row_z (
		.clk (clk), .coef (rows[2]), .x_s1 (x_s1), .y_s1 (y_s1), .z_s1 (z_s1),
		.res_s4 (out_z)
	);

	assign done     = v_s4;
	assign last_out = last_s4;
endmodule

### rtl/afft_checker.sv
// Port-level checker for the affine point transform, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module afft_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_in,
	input logic done,
	input logic last_out,
	input logic pready
);
	`AFFT_ASSERT(a_word_out, clk, arst_n, (start && !busy) |-> ##4 done)
	`AFFT_ASSERT(a_no_spurious, clk, arst_n, done |-> $past(start && !busy, 4))
	`AFFT_ASSERT(a_last_follows, clk, arst_n, done |-> (last_out == $past(last_in, 4)))
	`AFFT_NEVER(a_no_wait, clk, arst_n, !pready)
endmodule

bind affine_point_transform_unit afft_checker u_afft_checker (.*);
